### rtl/mspd_pkg.sv
// Shared types and constants for the Mode S preamble detector and demodulator.
`default_nettype none

package mspd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int RATIO_W     = 9;
    localparam int Q_FRAC      = 8;
    localparam int HALF_W      = 56;
    localparam int MSG_BITS    = 2 * HALF_W;
    localparam int DF_W        = 5;
    localparam int CFG_INDEX_W = 4;
    localparam int PROD_W      = SAMPLE_W + RATIO_W;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_RATIO = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_RATIO   = CFG_INDEX_W'(1);

    localparam logic [RATIO_W-1:0] PULSE_RATIO_RESET = RATIO_W'(179);
    localparam logic [RATIO_W-1:0] GAP_RATIO_RESET   = RATIO_W'(333);

    // Downlink formats that carry a short (56-bit) message.
    localparam logic [DF_W-1:0] DF_SHORT_ACAS = DF_W'(0);
    localparam logic [DF_W-1:0] DF_ALT_REPLY  = DF_W'(4);
    localparam logic [DF_W-1:0] DF_ID_REPLY   = DF_W'(5);
    localparam logic [DF_W-1:0] DF_ALL_CALL   = DF_W'(11);

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic [HALF_W-1:0] msg_first_half;
        logic [HALF_W-1:0] msg_second_half;
        logic              is_long;
        logic [DF_W-1:0]   downlink_format;
    } result_t;

    function automatic logic is_short_df(input logic [DF_W-1:0] df);
        return (df == DF_SHORT_ACAS) || (df == DF_ALT_REPLY) ||
               (df == DF_ID_REPLY) || (df == DF_ALL_CALL);
    endfunction

endpackage

`default_nettype wire

### rtl/mspd_window.sv
// Sample shift line with fill counter and the pending-test flag.
`default_nettype none

module mspd_window #(
    parameter int WINDOW_LEN = 240
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     shift_en,
    input  wire logic                                     test_done,
    input  wire mspd_pkg::sample_t                        sample_in,
    output logic [WINDOW_LEN-1:0][mspd_pkg::SAMPLE_W-1:0] window,
    output logic                                          test_pending
);
    import mspd_pkg::*;

    localparam int FILL_W = $clog2(WINDOW_LEN + 1);

    logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] window_reg;
    logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] window_next;
    logic [FILL_W-1:0]                   fill_reg;
    logic [FILL_W-1:0]                   fill_next;
    logic                                pend_reg;
    logic                                pend_next;
    logic                                full_after;

    // Index 0 holds the oldest sample; new samples enter at the top.
    always_comb begin
        for (int k = 0; k < WINDOW_LEN - 1; k++) begin
            window_next[k] = window_reg[k + 1];
        end
        window_next[WINDOW_LEN-1] = sample_in;
    end

    always_comb begin
        fill_next = fill_reg;
        if (fill_reg != FILL_W'(WINDOW_LEN)) begin
            fill_next = fill_reg + FILL_W'(1);
        end
        full_after = (fill_next == FILL_W'(WINDOW_LEN));
    end

    always_comb begin
        pend_next = pend_reg;
        if (shift_en) begin
            pend_next = full_after;
        end else if (test_done) begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            window_reg <= window_next;
        end
        if (!aresetn) begin
            fill_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            if (shift_en) begin
                fill_reg <= fill_next;
            end
            pend_reg <= pend_next;
        end
    end

    assign window       = window_reg;
    assign test_pending = pend_reg;

endmodule

`default_nettype wire

### rtl/mspd_detect.sv
// Preamble test and pulse-position bit slicing over the current window.
`default_nettype none

module mspd_detect #(
    parameter int PREAMBLE_SAMPLES = 16,
    parameter int LONG_BITS        = 112,
    parameter int SHORT_BITS       = 56,
    parameter int WINDOW_LEN       = 240
) (
    input  wire logic [WINDOW_LEN-1:0][mspd_pkg::SAMPLE_W-1:0] window,
    input  wire logic [mspd_pkg::RATIO_W-1:0]                 pulse_ratio,
    input  wire logic [mspd_pkg::RATIO_W-1:0]                 gap_ratio,
    output logic                                              match,
    output mspd_pkg::result_t                                 result
);
    import mspd_pkg::*;

    localparam int MAX_BITS = (LONG_BITS > SHORT_BITS) ? LONG_BITS : SHORT_BITS;

    sample_t             high;
    sample_t             low;
    logic [PROD_W-1:0]   pulse_th;
    logic [PROD_W-1:0]   gap_th;
    logic [PROD_W-1:0]   scaled [10];
    logic                ratio_ok;
    logic [MSG_BITS-1:0] slice_bits;
    logic [MSG_BITS-1:0] short_msg;
    logic [MSG_BITS-1:0] long_msg;
    logic [MSG_BITS-1:0] msg;
    logic [DF_W-1:0]     df;
    logic                short_df;

    assign high     = window[0];
    assign low      = window[5];
    assign pulse_th = PROD_W'(high) * PROD_W'(pulse_ratio);
    assign gap_th   = PROD_W'(low) * PROD_W'(gap_ratio);

    always_comb begin
        for (int k = 0; k < 10; k++) begin
            scaled[k] = PROD_W'({window[k], {Q_FRAC{1'b0}}});
        end
    end

    assign ratio_ok = ({1'b0, high} >= {low, 1'b0});

    // Pulses at samples 0, 2, 7 and 9; every other sample of the first ten is a gap.
    assign match = ratio_ok &&
                   (scaled[0] >= pulse_th) && (scaled[2] >= pulse_th) &&
                   (scaled[7] >= pulse_th) && (scaled[9] >= pulse_th) &&
                   (scaled[1] <= gap_th) && (scaled[3] <= gap_th) &&
                   (scaled[4] <= gap_th) && (scaled[5] <= gap_th) &&
                   (scaled[6] <= gap_th) && (scaled[8] <= gap_th);

    // A bit is one when its first half carries more energy than its second half.
    for (genvar i = 0; i < MSG_BITS; i++) begin : g_bit
        if (i < MAX_BITS) begin : g_slice
            assign slice_bits[i] = window[PREAMBLE_SAMPLES + 2*i] >
                                   window[PREAMBLE_SAMPLES + 2*i + 1];
        end else begin : g_none
            assign slice_bits[i] = 1'b0;
        end
        assign short_msg[i] = (i < SHORT_BITS) ? slice_bits[i] : 1'b0;
        assign long_msg[i]  = (i < LONG_BITS) ? slice_bits[i] : 1'b0;
    end

    assign df       = {slice_bits[0], slice_bits[1], slice_bits[2],
                       slice_bits[3], slice_bits[4]};
    assign short_df = is_short_df(df);
    assign msg      = short_df ? short_msg : long_msg;

    // The first message bit lands at the most significant position of each half.
    always_comb begin
        for (int k = 0; k < HALF_W; k++) begin
            result.msg_first_half[HALF_W-1-k]  = msg[k];
            result.msg_second_half[HALF_W-1-k] = msg[HALF_W + k];
        end
        result.is_long         = !short_df;
        result.downlink_format = df;
    end

endmodule

`default_nettype wire

### rtl/mode_s_preamble_ppm_demodulator.sv
// Top level of the Mode S preamble detector and pulse-position demodulator.
// A sample that completes a preamble match reaches m_valid through the window register and
// then the result register; the test waits while an earlier result is still untaken.
// Throughput: one sample per cycle; the input stalls only while a second match waits
// behind an untaken result. Reset clears the fill count, pending and output valid
// flags and loads ratios 179 and 333; window contents need no reset.
`default_nettype none

module mode_s_preamble_ppm_demodulator #(
    parameter int PREAMBLE_SAMPLES = 16,
    parameter int LONG_BITS        = 112,
    parameter int SHORT_BITS       = 56
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Sample input channel.
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [mspd_pkg::SAMPLE_W-1:0]     s_sample_magnitude,
    // Message output channel.
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [mspd_pkg::HALF_W-1:0]            m_msg_first_half,
    output logic [mspd_pkg::HALF_W-1:0]            m_msg_second_half,
    output logic                                   m_is_long,
    output logic [mspd_pkg::DF_W-1:0]              m_downlink_format,
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mspd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [mspd_pkg::RATIO_W-1:0]      cfg_wdata
);
    import mspd_pkg::*;

    localparam int MAX_BITS   = (LONG_BITS > SHORT_BITS) ? LONG_BITS : SHORT_BITS;
    localparam int WINDOW_LEN = PREAMBLE_SAMPLES + 2 * MAX_BITS;

    logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] window;
    logic                                test_pending;
    logic                                match;
    logic                                out_free;
    logic                                load;
    logic                                shift_en;
    logic                                test_done;
    result_t                             det_result;

    logic [RATIO_W-1:0] pulse_ratio_reg;
    logic [RATIO_W-1:0] gap_ratio_reg;
    logic               m_valid_reg;
    logic               m_valid_next;
    result_t            result_reg;

    // The window register acts as the input stage: when the window becomes full,
    // every accepted sample raises a pending test that is evaluated in the next
    // cycle on the shifted window. A pending test is finished when it fails or
    // when the result register can take its message.
    assign out_free  = !m_valid_reg || m_ready;
    assign test_done = test_pending && (!match || out_free);
    assign load      = test_pending && match && out_free;
    assign s_ready   = !test_pending || test_done;
    assign shift_en  = s_valid && s_ready;

    mspd_window #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .shift_en    (shift_en),
        .test_done   (test_done),
        .sample_in   (s_sample_magnitude),
        .window      (window),
        .test_pending(test_pending)
    );

    mspd_detect #(
        .PREAMBLE_SAMPLES(PREAMBLE_SAMPLES),
        .LONG_BITS       (LONG_BITS),
        .SHORT_BITS      (SHORT_BITS),
        .WINDOW_LEN      (WINDOW_LEN)
    ) u_detect (
        .window     (window),
        .pulse_ratio(pulse_ratio_reg),
        .gap_ratio  (gap_ratio_reg),
        .match      (match),
        .result     (det_result)
    );

    // The result register holds one message until the consumer takes it.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= det_result;
        end
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            pulse_ratio_reg <= PULSE_RATIO_RESET;
            gap_ratio_reg   <= GAP_RATIO_RESET;
        end else begin
            m_valid_reg <= m_valid_next;
            // Writes to indexes past the register list are dropped.
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_PULSE_RATIO: pulse_ratio_reg <= cfg_wdata;
                    CFG_GAP_RATIO:   gap_ratio_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    assign m_valid           = m_valid_reg;
    assign m_msg_first_half  = result_reg.msg_first_half;
    assign m_msg_second_half = result_reg.msg_second_half;
    assign m_is_long         = result_reg.is_long;
    assign m_downlink_format = result_reg.downlink_format;

endmodule

`default_nettype wire

### rtl/mspd_checker.sv
// Port-level checks for the demodulator and the bind that attaches them.
`default_nettype none

module mspd_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [mspd_pkg::HALF_W-1:0]   m_msg_first_half,
    input wire logic [mspd_pkg::HALF_W-1:0]   m_msg_second_half,
    input wire logic                          m_is_long,
    input wire logic [mspd_pkg::DF_W-1:0]     m_downlink_format
);
    import mspd_pkg::*;

    // A waiting message stays put until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_msg_first_half) &&
                                $stable(m_msg_second_half) && $stable(m_downlink_format))
        else $error("output item changed while stalled");

    // The format code is the first five message bits.
    a_df: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_downlink_format == m_msg_first_half[HALF_W-1 -: DF_W])
        else $error("downlink format differs from leading message bits");

    // The length flag follows the format code.
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_is_long == !is_short_df(m_downlink_format))
        else $error("length flag inconsistent with downlink format");

    // A short message has no second half.
    a_short: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_long |-> m_msg_second_half == '0)
        else $error("short message carries second half bits");

endmodule

bind mode_s_preamble_ppm_demodulator mspd_checker u_mspd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_msg_first_half (m_msg_first_half),
    .m_msg_second_half(m_msg_second_half),
    .m_is_long        (m_is_long),
    .m_downlink_format(m_downlink_format)
);

`default_nettype wire
